// ----- design/eeprom_block_patch_decompressor_top_defines.svh -----
// ----------------------------------------------------------------------------
// EEPROM block patch decompressor assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef EEPROM_BLOCK_PATCH_DECOMPRESSOR_TOP_DEFINES_SVH
`define EEPROM_BLOCK_PATCH_DECOMPRESSOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EBPD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define EBPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define EBPD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EBPD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- design/ebpd_pkg.sv -----
// ----------------------------------------------------------------------------
// EEPROM block patch decompressor package
// Types, codes and constants shared by the decompressor modules.
// ----------------------------------------------------------------------------
package ebpd_pkg;

   localparam int MAX_IMAGE_BYTES = 4096;

   localparam logic [12:0] BOUND_MAX = 13'(MAX_IMAGE_BYTES);
   localparam logic [12:0] SPOT_MAX  = 13'h1fff;

   localparam logic [2:0] COMP_NONE  = 3'd0;
   localparam logic [2:0] COMP_BLOCK = 3'd3;

   localparam logic [1:0] CSR_COMP_CODE      = 2'd0;
   localparam logic [1:0] CSR_PAYLOAD_LENGTH = 2'd1;
   localparam logic [1:0] CSR_IMAGE_SIZE     = 2'd2;

   typedef enum logic [2:0] {
      PH_OFFSET = 3'b001,
      PH_LENGTH = 3'b010,
      PH_DATA   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK            = 2'd0,
      ST_SIZE_MISMATCH = 2'd1,
      ST_BAD_RESTORE   = 2'd2,
      ST_UNKNOWN_CODE  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  comp_code;
      logic [10:0] payload_length;
      logic [12:0] image_size;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [12:0] spot;
      logic [7:0]  run_left;
      logic [10:0] byte_count;
      status_type  error;
   } state_type;

   typedef struct packed {
      logic        write_enable;
      logic [11:0] write_address;
      logic [7:0]  write_data;
      logic        block_done;
      status_type  status;
   } result_type;

   localparam cfg_type CFG_RESET = '{
      comp_code:      3'd0,
      payload_length: 11'd0,
      image_size:     13'd4096
   };

   localparam state_type STATE_RESET = '{
      phase:      PH_OFFSET,
      spot:       13'd0,
      run_left:   8'd0,
      byte_count: 11'd0,
      error:      ST_OK
   };

endpackage

// ----- design/ebpd_step.sv -----
// ----------------------------------------------------------------------------
// EEPROM block patch decompressor step logic
// Next state and result for one payload byte.
// ----------------------------------------------------------------------------
module ebpd_step (
   input  ebpd_pkg::cfg_type    cfg_i,
   input  ebpd_pkg::state_type  state_i,
   input  logic [7:0]           byte_i,
   output ebpd_pkg::state_type  state_o,
   output ebpd_pkg::result_type result_o
);
   import ebpd_pkg::*;

   logic [12:0] size;
   logic [13:0] spot_sum;
   logic [7:0]  run_dec;
   logic [11:0] count_inc;

   always_comb begin
      size      = (cfg_i.image_size > BOUND_MAX) ? BOUND_MAX : cfg_i.image_size;
      spot_sum  = {1'b0, state_i.spot} + {6'd0, byte_i};
      run_dec   = (state_i.run_left != 8'd0) ? state_i.run_left - 8'd1 : 8'd0;
      count_inc = {1'b0, state_i.byte_count} + 12'd1;

      state_o  = state_i;
      result_o = '0;

      if (state_i.error == ST_OK) begin
         case (cfg_i.comp_code)
            COMP_NONE: begin
               if ({2'b00, cfg_i.payload_length} != cfg_i.image_size) begin
                  state_o.error = ST_SIZE_MISMATCH;
               end else if ({2'b00, state_i.byte_count} < size) begin
                  result_o.write_enable  = 1'b1;
                  result_o.write_address = {1'b0, state_i.byte_count};
                  result_o.write_data    = byte_i;
               end
            end
            COMP_BLOCK: begin
               case (state_i.phase)
                  PH_LENGTH: begin
                     if (byte_i == 8'd0) begin
                        state_o.phase = PH_OFFSET;
                     end else if (spot_sum > {1'b0, size}) begin
                        state_o.error = ST_BAD_RESTORE;
                     end else begin
                        state_o.run_left = byte_i;
                        state_o.phase    = PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     // spot < size <= 4096 here, so the low 12 bits are the address
                     if (state_i.spot < size) begin
                        result_o.write_enable  = 1'b1;
                        result_o.write_address = state_i.spot[11:0];
                        result_o.write_data    = byte_i;
                     end
                     if (state_i.spot < SPOT_MAX) begin
                        state_o.spot = state_i.spot + 13'd1;
                     end
                     state_o.run_left = run_dec;
                     if (run_dec == 8'd0) begin
                        state_o.phase = PH_OFFSET;
                     end
                  end
                  default: begin
                     state_o.spot  = (spot_sum > {1'b0, SPOT_MAX}) ? SPOT_MAX
                                                                   : spot_sum[12:0];
                     state_o.phase = PH_LENGTH;
                  end
               endcase
            end
            default: begin
               state_o.error = ST_UNKNOWN_CODE;
            end
         endcase
      end

      result_o.status     = state_o.error;
      result_o.block_done = (count_inc >= {1'b0, cfg_i.payload_length});

      // last byte of the block re-arms the whole state record
      if (result_o.block_done) begin
         state_o = STATE_RESET;
      end else begin
         state_o.byte_count = state_i.byte_count + 11'd1;
      end
   end

endmodule

// ----- design/eeprom_block_patch_decompressor_top.sv -----
// One payload byte per request, one result per request. A request is taken into an input
// register and its result lands in an output register when it can move, so the block
// sustains one byte per clock while the consumer does not stall; record phase, write spot,
// run count and byte count are updated together as the result is registered.
// While a result waits on a stalled consumer the input register can hold one more request.
// Configuration writes are taken in any cycle and must only be issued while idle.
`include "eeprom_block_patch_decompressor_top_defines.svh"

// ----------------------------------------------------------------------------
// EEPROM block patch decompressor
// Turns compressed block payload bytes into image write commands.
// ----------------------------------------------------------------------------
module eeprom_block_patch_decompressor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_write_enable,
   output logic [11:0] rsp_write_address,
   output logic [7:0]  rsp_write_data,
   output logic        rsp_block_done,
   output logic [1:0]  rsp_status
);
   import ebpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   state_type  state_next;
   result_type result_next;
   result_type rsp_ff, rsp_in;
   logic       req_valid_ff, req_valid_in;
   logic [7:0] req_byte_ff, req_byte_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       move;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COMP_CODE:      cfg_in.comp_code      = csr_data[2:0];
            CSR_PAYLOAD_LENGTH: cfg_in.payload_length = csr_data[10:0];
            CSR_IMAGE_SIZE:     cfg_in.image_size     = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   ebpd_step u_step (
      .cfg_i    (cfg_ff),
      .state_i  (state_ff),
      .byte_i   (req_byte_ff),
      .state_o  (state_next),
      .result_o (result_next)
   );

   // request moves into the result register when that register is free or draining
   assign move      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || move;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_byte_in  = req_byte_ff;
      if (req_ready) begin
         req_valid_in = req_valid;
         req_byte_in  = req_in_byte;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      state_in     = state_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result_next;
         state_in     = state_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_byte_ff <= req_byte_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = rsp_ff.write_enable;
   assign rsp_write_address = rsp_ff.write_address;
   assign rsp_write_data    = rsp_ff.write_data;
   assign rsp_block_done    = rsp_ff.block_done;
   assign rsp_status        = rsp_ff.status;

   `EBPD_ASSERT_IMPLY(a_idle_fields_zero, clock, reset,
      rsp_valid_ff && !rsp_ff.write_enable,
      rsp_ff.write_address == 12'd0 && rsp_ff.write_data == 8'd0)

   `EBPD_ASSERT_IMPLY(a_no_write_on_error, clock, reset,
      rsp_valid_ff && rsp_ff.status != ST_OK, !rsp_ff.write_enable)

   `EBPD_ASSERT_NEXT(a_rearm_after_done, clock, reset,
      move && result_next.block_done,
      state_ff.byte_count == 11'd0 && state_ff.error == ST_OK && state_ff.phase == PH_OFFSET)

   `EBPD_ASSERT_NEXT(a_error_latched, clock, reset,
      move && !result_next.block_done && state_ff.error != ST_OK,
      state_ff.error == $past(state_ff.error))

endmodule
